// ----- hdl/pfa_pkg.sv -----
// Shared types and constants for the page frame allocator.
// Holds command and status codes, controller states and the stack control group.
// No dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int PFA_NUM_PAGES  = 32768;
  localparam int PFA_COUNT_BITS = 8;

  localparam int PAGE_W  = 15;
  localparam int REF_W   = 8;
  localparam int CFG_W   = 16;
  localparam int LIMIT_W = 16;

  // Pages beyond what a page field can name are never touched.
  localparam int PAGE_SPAN = 1 << PAGE_W;

  typedef enum logic [2:0] {
    CMD_ALLOC    = 3'd0,
    CMD_FREE     = 3'd1,
    CMD_ADD_REF  = 3'd2,
    CMD_DROP_REF = 3'd3,
    CMD_READ_REF = 3'd4,
    CMD_RST_REF  = 3'd5,
    CMD_DONATE   = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_POOLED  = 3'd1,
    STAT_NOMEM   = 3'd2,
    STAT_BADADDR = 3'd3,
    STAT_UNDER   = 3'd4,
    STAT_OVER    = 3'd5
  } stat_t;

  typedef enum logic [0:0] {
    CFG_FIRST_PAGE = 1'b0,
    CFG_PAGE_LIMIT = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_EXEC  = 2'd2
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

// ----- hdl/pfa_if.sv -----
// Valid/ready channel interfaces for command words and result words.
// Depends on pfa_pkg for field widths.
`timescale 1ns / 1ps

interface pfa_in_if;
  import pfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        command;
  logic [PAGE_W-1:0] page_index;

  modport source (output valid, command, page_index, input ready);
  modport sink   (input valid, command, page_index, output ready);
endinterface

interface pfa_out_if;
  import pfa_pkg::*;
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_out;
  logic [REF_W-1:0]  ref_value;
  logic [2:0]        status;

  modport source (output valid, page_out, ref_value, status, input ready);
  modport sink   (input valid, page_out, ref_value, status, output ready);
endinterface

// ----- hdl/page_frame_allocator_refcount.sv -----
// Page frame allocator with per-page reference counts and a free-page stack.
// The command word and its count and stack RAM reads are registered when the
// command is taken; the result word is registered when it executes, which
// waits while an earlier result word is still held. A new command word is
// taken only after the previous one has executed and written back its count.
// Reset: the stack is empty and a clearing pass writes zero to every count,
// min(NUM_PAGES, 32768) of them, during which no command word is taken.
`timescale 1ns / 1ps

module page_frame_allocator_refcount import pfa_pkg::*; #(
  parameter int NUM_PAGES  = PFA_NUM_PAGES,
  parameter int COUNT_BITS = PFA_COUNT_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  pfa_in_if.sink           in_ch,
  pfa_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CNT_DEPTH = (NUM_PAGES < PAGE_SPAN) ? NUM_PAGES : PAGE_SPAN;
  localparam int CNT_AW    = $clog2(CNT_DEPTH);
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  state_t state_r, state_nxt;

  logic [PAGE_W-1:0]  first_page_r;
  logic [LIMIT_W-1:0] page_limit_r;
  logic [CNT_AW-1:0]  clr_addr_r;

  cmd_t              cmd_r;
  logic [PAGE_W-1:0] pg_r;
  logic              range_ok_r;
  logic              pg_ok_r;

  logic              out_valid_r;
  logic [PAGE_W-1:0] page_out_r;
  logic [REF_W-1:0]  ref_value_r;
  stat_t             status_r;

  logic accept;
  logic exec_go;
  logic clearing;
  logic pg_ok_in;
  logic range_ok_in;

  logic [COUNT_BITS-1:0] cnt_rd;
  logic [PAGE_W-1:0]     stk_rd;
  logic                  stk_empty;
  stk_ctl_t              stk_ctl;

  logic                  res_cnt_we;
  logic [CNT_AW-1:0]     res_cnt_addr;
  logic [COUNT_BITS-1:0] res_cnt_val;
  logic                  res_push;
  logic                  res_pop;
  logic [PAGE_W-1:0]     res_page;
  logic [COUNT_BITS-1:0] res_ref;
  stat_t                 res_stat;
  logic [31:0]           res_ref_wide;

  logic                  ram_we;
  logic [CNT_AW-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == CNT_AW'(CNT_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    exec_go     = 1'b0;
    clearing    = 1'b0;
    case (state_r)
      S_CLEAR: clearing = 1'b1;
      S_IDLE:  in_ch.ready = 1'b1;
      S_EXEC:  exec_go = !out_valid_r || out_ch.ready;
      default: clearing = 1'b0;
    endcase
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
      page_limit_r <= LIMIT_W'(PAGE_SPAN);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_PAGE: first_page_r <= cfg_wdata[PAGE_W-1:0];
        CFG_PAGE_LIMIT: page_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default:        first_page_r <= first_page_r;
      endcase
    end
  end

  assign pg_ok_in    = (32'(in_ch.page_index) < NUM_PAGES);
  assign range_ok_in = pg_ok_in && (in_ch.page_index >= first_page_r) &&
                       (LIMIT_W'(in_ch.page_index) < page_limit_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= cmd_t'(in_ch.command);
      pg_r       <= in_ch.page_index;
      pg_ok_r    <= pg_ok_in;
      range_ok_r <= range_ok_in;
    end
  end

  // Execute: the count and stack words read at accept are now valid.
  always_comb begin
    res_cnt_we   = 1'b0;
    res_cnt_addr = pg_r[CNT_AW-1:0];
    res_cnt_val  = cnt_rd;
    res_push     = 1'b0;
    res_pop      = 1'b0;
    res_page     = '0;
    res_ref      = '0;
    res_stat     = STAT_OK;
    case (cmd_r)
      CMD_ALLOC: begin
        if (stk_empty) begin
          res_stat = STAT_NOMEM;
        end else begin
          res_pop      = 1'b1;
          res_page     = stk_rd;
          res_ref      = CNT_ONE;
          res_cnt_addr = stk_rd[CNT_AW-1:0];
          res_cnt_val  = CNT_ONE;
          res_cnt_we   = (32'(stk_rd) < NUM_PAGES);
        end
      end
      CMD_FREE: begin
        if (!range_ok_r) begin
          res_stat = STAT_BADADDR;
        end else if (cnt_rd == '0) begin
          res_stat = STAT_UNDER;
        end else begin
          res_cnt_we  = 1'b1;
          res_cnt_val = cnt_rd - 1'b1;
          if (cnt_rd == CNT_ONE) begin
            res_push = 1'b1;
            res_stat = STAT_POOLED;
          end else begin
            res_ref = cnt_rd - 1'b1;
          end
        end
      end
      CMD_DONATE: begin
        // Increment then free: the count ends where it began.
        if (!range_ok_r) begin
          res_stat = STAT_BADADDR;
        end else if (&cnt_rd) begin
          res_stat = STAT_OVER;
          res_ref  = cnt_rd;
        end else if (cnt_rd == '0) begin
          res_push = 1'b1;
          res_stat = STAT_POOLED;
        end else begin
          res_ref = cnt_rd;
        end
      end
      CMD_ADD_REF: begin
        if (!pg_ok_r) begin
          res_stat = STAT_BADADDR;
        end else if (&cnt_rd) begin
          res_stat = STAT_OVER;
          res_ref  = cnt_rd;
        end else begin
          res_cnt_we  = 1'b1;
          res_cnt_val = cnt_rd + 1'b1;
          res_ref     = cnt_rd + 1'b1;
        end
      end
      CMD_DROP_REF: begin
        if (!pg_ok_r) begin
          res_stat = STAT_BADADDR;
        end else if (cnt_rd == '0) begin
          res_stat = STAT_UNDER;
        end else begin
          res_cnt_we  = 1'b1;
          res_cnt_val = cnt_rd - 1'b1;
          res_ref     = cnt_rd - 1'b1;
        end
      end
      CMD_READ_REF: begin
        if (!pg_ok_r) begin
          res_stat = STAT_BADADDR;
        end else begin
          res_ref = cnt_rd;
        end
      end
      CMD_RST_REF: begin
        if (!pg_ok_r) begin
          res_stat = STAT_BADADDR;
        end else begin
          res_cnt_we  = 1'b1;
          res_cnt_val = '0;
        end
      end
      default: res_stat = STAT_OK;
    endcase
  end

  assign res_ref_wide = 32'(res_ref);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      page_out_r  <= res_page;
      ref_value_r <= res_ref_wide[REF_W-1:0];
      status_r    <= res_stat;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.page_out  = page_out_r;
  assign out_ch.ref_value = ref_value_r;
  assign out_ch.status    = status_r;

  assign ram_we    = clearing || (exec_go && res_cnt_we);
  assign ram_waddr = clearing ? clr_addr_r : res_cnt_addr;
  assign ram_wdata = clearing ? '0 : res_cnt_val;

  pfa_cnt_ram #(
    .DEPTH (CNT_DEPTH),
    .AW    (CNT_AW),
    .DW    (COUNT_BITS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_ch.page_index[CNT_AW-1:0]),
    .rdata (cnt_rd)
  );

  assign stk_ctl.rd_en = accept;
  assign stk_ctl.push  = exec_go && res_push;
  assign stk_ctl.pop   = exec_go && res_pop;

  pfa_stack #(
    .NUM_PAGES (NUM_PAGES)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (stk_ctl),
    .push_data (pg_r),
    .rd_data   (stk_rd),
    .empty     (stk_empty)
  );

`ifndef NO_ASSERTIONS
  a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r && state_r == S_IDLE)
    else $error("executed command did not produce a result word");

  a_badaddr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r == STAT_BADADDR |-> ref_value_r == '0 && page_out_r == '0)
    else $error("bad address result carries data");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_CLEAR && state_r == S_CLEAR |-> !out_valid_r)
    else $error("result word during the clearing pass");
`endif

endmodule

// ----- hdl/pfa_cnt_ram.sv -----
// Single-port-write, single-port-read synchronous RAM for the reference counts.
// Read data is registered; depends on nothing.
`timescale 1ns / 1ps

module pfa_cnt_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/pfa_stack.sv -----
// Free-page stack: a synchronous RAM of page numbers and its top pointer.
// Depends on pfa_pkg for the page width and the control struct.
`timescale 1ns / 1ps

module pfa_stack import pfa_pkg::*; #(
  parameter int NUM_PAGES = PFA_NUM_PAGES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stk_ctl_t          ctl,
  input  logic [PAGE_W-1:0] push_data,
  output logic [PAGE_W-1:0] rd_data,
  output logic              empty
);

  localparam int SAW = $clog2(NUM_PAGES);
  localparam int TW  = $clog2(NUM_PAGES + 1);

  logic [PAGE_W-1:0] mem [NUM_PAGES];
  logic [TW-1:0]     top_r;
  logic [TW-1:0]     top_nxt;
  logic [TW-1:0]     top_dec;
  logic              full;

  assign top_dec = top_r - 1'b1;
  assign full    = (top_r == TW'(NUM_PAGES));
  assign empty   = (top_r == '0);

  always_comb begin
    top_nxt = top_r;
    if (ctl.pop && !empty) begin
      top_nxt = top_dec;
    end else if (ctl.push && !full) begin
      top_nxt = top_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else begin
      top_r <= top_nxt;
    end
  end

  // The read at top-1 is issued when a command is taken; its word is only
  // used by an alloc, which first checks that the stack is not empty.
  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      mem[top_r[SAW-1:0]] <= push_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[top_dec[SAW-1:0]];
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop))
    else $error("stack push and pop in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> !empty)
    else $error("pop from an empty stack");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TW'(NUM_PAGES))
    else $error("stack pointer beyond depth");
`endif

endmodule
